/* hdl/lssf_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the line sensor steering and features unit.
// No dependencies; every other file refers to it by scoped names.
package lssf_pkg;

    localparam int SAMPLE_W = 12;
    localparam int GAIN_W   = 16;
    localparam int ERR_W    = 16;
    localparam int CMD_W    = 20;
    localparam int MASK_W   = 7;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // divider geometry: quotient fits 15 bits, denominator at most 5 * 4095
    localparam int QUOT_W = 15;
    localparam int DEN_W  = 15;
    localparam int NUMAB_W = 15;
    localparam int FRAC_W = 12;
    localparam int MAG_W  = NUMAB_W + FRAC_W;
    localparam int REM_W  = DEN_W + 1;
    localparam int CNT_W  = 4;
    localparam logic [CNT_W-1:0] ITER_LAST = CNT_W'(QUOT_W - 1);

    // PD datapath
    localparam int MUL_W  = 17;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int SHR_W  = ACC_W - FRAC_W;

    localparam logic signed [CMD_W-1:0] CMD_MAX = {1'b0, {(CMD_W-1){1'b1}}};
    localparam logic signed [CMD_W-1:0] CMD_MIN = {1'b1, {(CMD_W-1){1'b0}}};

    localparam logic [GAIN_W-1:0]   PROP_GAIN_RST   = 16'd819;
    localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST  = 16'd0;
    localparam logic [SAMPLE_W-1:0] LINE_THR_RST    = 12'd2700;
    localparam logic [SAMPLE_W-1:0] CENTER_THR_RST  = 12'd4000;

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_THR   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_THR = 2'd3;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sense_far_left;
        logic [SAMPLE_W-1:0] sense_left;
        logic [SAMPLE_W-1:0] sense_middle;
        logic [SAMPLE_W-1:0] sense_right;
        logic [SAMPLE_W-1:0] sense_far_right;
        logic [SAMPLE_W-1:0] sense_center_a;
        logic [SAMPLE_W-1:0] sense_center_b;
    } frame_t;

    typedef struct packed {
        logic signed [CMD_W-1:0] steer_command;
        logic signed [ERR_W-1:0] position_error;
        logic                    no_signal;
        logic [MASK_W-1:0]       feature_mask;
    } result_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quotient;
    } div_status_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_MULP = 5'b00100,
        ST_MULD = 5'b01000,
        ST_SAT  = 5'b10000
    } state_t;

endpackage

/* hdl/lssf_divider.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the position error.
// Depends on lssf_pkg.
module lssf_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lssf_pkg::MAG_W-1:0]    dividend,
    input  logic [lssf_pkg::DEN_W-1:0]    divisor,
    output lssf_pkg::div_status_t         status
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [lssf_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [lssf_pkg::REM_W-1:0]       rem_reg, rem_next;
    logic [lssf_pkg::QUOT_W-1:0]      shq_reg, shq_next;
    logic [lssf_pkg::DEN_W-1:0]       den_reg, den_next;
    logic [lssf_pkg::REM_W-1:0]       trial;
    logic                             fits;

    // the quotient stays below 2^15, so the top dividend bits are already below the divisor
    assign trial = {rem_reg[lssf_pkg::REM_W-2:0], shq_reg[lssf_pkg::QUOT_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        shq_next  = shq_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = lssf_pkg::REM_W'(dividend[lssf_pkg::MAG_W-1:lssf_pkg::QUOT_W]);
            shq_next  = dividend[lssf_pkg::QUOT_W-1:0];
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (trial - {1'b0, den_reg}) : trial;
            shq_next = {shq_reg[lssf_pkg::QUOT_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == lssf_pkg::ITER_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        shq_reg <= shq_next;
        den_reg <= den_next;
    end

    assign status.done     = done_reg;
    assign status.quotient = shq_reg;

endmodule

/* hdl/lssf_features.sv */
`timescale 1ns / 1ps
// Black-line feature tests of one frame against the two thresholds.
// Depends on lssf_pkg.
module lssf_features (
    input  lssf_pkg::frame_t                  frame,
    input  logic [lssf_pkg::SAMPLE_W-1:0]     line_thr,
    input  logic [lssf_pkg::SAMPLE_W-1:0]     center_thr,
    output logic [lssf_pkg::MASK_W-1:0]       mask
);

    logic b0, b1, b2, b3, b4, b5, b6;
    logic centers;

    assign b0 = frame.sense_far_left  >= line_thr;
    assign b1 = frame.sense_left      >= line_thr;
    assign b2 = frame.sense_middle    >= line_thr;
    assign b3 = frame.sense_right     >= line_thr;
    assign b4 = frame.sense_far_right >= line_thr;
    assign b5 = frame.sense_center_a  >= line_thr;
    assign b6 = frame.sense_center_b  >= line_thr;
    assign centers = b5 | b6;

    always_comb
    begin
        mask[0] = b0 & b2 & b4;
        mask[1] = (frame.sense_center_a >= center_thr) | (frame.sense_center_b >= center_thr);
        mask[2] = b2 & b5 & b6;
        mask[3] = b0 | b1 | b2 | b3 | b4;
        mask[4] = centers & b2;
        mask[5] = centers | b3;
        mask[6] = centers | b0;
    end

endmodule

/* hdl/line_sensor_steering_and_features_unit.sv */
`timescale 1ns / 1ps
// Top level of the line sensor steering and features unit.
// Depends on lssf_pkg, lssf_divider and lssf_features.

// One frame of seven samples in, one result word out. From acceptance to the
// result register a frame passes capture, the bit-serial divider that forms
// the position error, the divider's report, the shared multiplier
// (proportional term, then derivative term) and scaling with saturation,
// which waits while the output register holds an untaken word. A frame with
// zero front sum skips the divider. in_stall stays high while a frame is in
// work; a finished result sits in the output register, and the next frame is
// taken while it waits. Gains and thresholds are to be written through the
// cfg_we/cfg_index/cfg_data port only while idle; the unit does not check it.
module line_sensor_steering_and_features_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  lssf_pkg::frame_t                  in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output lssf_pkg::result_t                 out_data,
    input  logic                              cfg_we,
    input  logic [lssf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lssf_pkg::CFG_W-1:0]        cfg_data
);

    lssf_pkg::state_t                   state_reg, state_next;
    logic [lssf_pkg::GAIN_W-1:0]        prop_gain_reg, deriv_gain_reg;
    logic [lssf_pkg::SAMPLE_W-1:0]      line_thr_reg, center_thr_reg;
    logic signed [lssf_pkg::ERR_W-1:0]  prev_err_reg;
    logic signed [lssf_pkg::ERR_W-1:0]  err_reg;
    logic                               sign_reg, nosig_reg;
    logic [lssf_pkg::MASK_W-1:0]        mask_reg;
    logic signed [lssf_pkg::ACC_W-1:0]  acc_reg;
    logic                               out_valid_reg;
    lssf_pkg::result_t                  out_reg;

    logic                               accept;
    logic                               out_take;
    logic                               out_load;
    logic signed [16:0]                 num;
    logic [lssf_pkg::NUMAB_W-1:0]       num_abs;
    logic [lssf_pkg::DEN_W-1:0]         den;
    logic [lssf_pkg::MASK_W-1:0]        mask;
    lssf_pkg::div_status_t              div_status;
    logic signed [lssf_pkg::ERR_W-1:0]  div_err;
    logic signed [lssf_pkg::MUL_W-1:0]  change;
    logic signed [lssf_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic signed [lssf_pkg::PROD_W-1:0] prod;
    logic signed [lssf_pkg::SHR_W-1:0]  scaled;
    logic signed [lssf_pkg::CMD_W-1:0]  cmd_sat;

    assign in_stall = (state_reg != lssf_pkg::ST_IDLE);
    assign accept   = in_valid & ~in_stall;
    assign out_take = out_valid_reg & ~out_stall;
    assign out_load = (state_reg == lssf_pkg::ST_SAT) & (~out_valid_reg | ~out_stall);

    // front weights -4, -1, 0, 1, 6
    assign num = -($signed({5'd0, in_data.sense_far_left}) <<< 2)
                 - $signed({5'd0, in_data.sense_left})
                 + $signed({5'd0, in_data.sense_right})
                 + ($signed({5'd0, in_data.sense_far_right}) <<< 2)
                 + ($signed({5'd0, in_data.sense_far_right}) <<< 1);
    assign num_abs = num[16] ? lssf_pkg::NUMAB_W'(-num) : lssf_pkg::NUMAB_W'(num);
    assign den = lssf_pkg::DEN_W'({3'd0, in_data.sense_far_left})
               + lssf_pkg::DEN_W'({3'd0, in_data.sense_left})
               + lssf_pkg::DEN_W'({3'd0, in_data.sense_middle})
               + lssf_pkg::DEN_W'({3'd0, in_data.sense_right})
               + lssf_pkg::DEN_W'({3'd0, in_data.sense_far_right});

    lssf_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && (den != '0)),
        .dividend ({num_abs, {lssf_pkg::FRAC_W{1'b0}}}),
        .divisor  (den),
        .status   (div_status)
    );

    lssf_features u_feat (
        .frame      (in_data),
        .line_thr   (line_thr_reg),
        .center_thr (center_thr_reg),
        .mask       (mask)
    );

    assign div_err = sign_reg ? -$signed({1'b0, div_status.quotient})
                              :  $signed({1'b0, div_status.quotient});

    assign change = {err_reg[lssf_pkg::ERR_W-1], err_reg}
                  - {prev_err_reg[lssf_pkg::ERR_W-1], prev_err_reg};

    // one multiplier, proportional term first, derivative term next
    always_comb
    begin
        if (state_reg == lssf_pkg::ST_MULD)
        begin
            mul_a = change;
            mul_b = $signed({1'b0, deriv_gain_reg});
        end
        else
        begin
            mul_a = {err_reg[lssf_pkg::ERR_W-1], err_reg};
            mul_b = $signed({1'b0, prop_gain_reg});
        end
    end
    assign prod = mul_a * mul_b;

    // arithmetic shift is the floor of the Q.12 scaling
    assign scaled = lssf_pkg::SHR_W'(acc_reg >>> lssf_pkg::FRAC_W);

    always_comb
    begin
        priority if (scaled > lssf_pkg::SHR_W'(lssf_pkg::CMD_MAX))
            cmd_sat = lssf_pkg::CMD_MAX;
        else if (scaled < lssf_pkg::SHR_W'(lssf_pkg::CMD_MIN))
            cmd_sat = lssf_pkg::CMD_MIN;
        else
            cmd_sat = lssf_pkg::CMD_W'(scaled);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lssf_pkg::ST_IDLE:
                if (accept)
                    state_next = (den == '0) ? lssf_pkg::ST_MULP : lssf_pkg::ST_DIV;
            lssf_pkg::ST_DIV:
                if (div_status.done)
                    state_next = lssf_pkg::ST_MULP;
            lssf_pkg::ST_MULP:
                state_next = lssf_pkg::ST_MULD;
            lssf_pkg::ST_MULD:
                state_next = lssf_pkg::ST_SAT;
            lssf_pkg::ST_SAT:
                if (out_load)
                    state_next = lssf_pkg::ST_IDLE;
            default:
                state_next = lssf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lssf_pkg::ST_IDLE;
            prop_gain_reg  <= lssf_pkg::PROP_GAIN_RST;
            deriv_gain_reg <= lssf_pkg::DERIV_GAIN_RST;
            line_thr_reg   <= lssf_pkg::LINE_THR_RST;
            center_thr_reg <= lssf_pkg::CENTER_THR_RST;
            prev_err_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    lssf_pkg::CFG_PROP_GAIN:  prop_gain_reg  <= cfg_data;
                    lssf_pkg::CFG_DERIV_GAIN: deriv_gain_reg <= cfg_data;
                    lssf_pkg::CFG_LINE_THR:   line_thr_reg   <= cfg_data[lssf_pkg::SAMPLE_W-1:0];
                    lssf_pkg::CFG_CENTER_THR: center_thr_reg <= cfg_data[lssf_pkg::SAMPLE_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == lssf_pkg::ST_MULD)
                prev_err_reg <= err_reg;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sign_reg  <= num[16];
            nosig_reg <= (den == '0);
            mask_reg  <= mask;
            err_reg   <= '0;
        end
        else if ((state_reg == lssf_pkg::ST_DIV) && div_status.done)
            err_reg <= div_err;
        if (state_reg == lssf_pkg::ST_MULP)
            acc_reg <= lssf_pkg::ACC_W'(prod);
        else if (state_reg == lssf_pkg::ST_MULD)
            acc_reg <= acc_reg + lssf_pkg::ACC_W'(prod);
        if (out_load)
        begin
            out_reg.steer_command  <= cmd_sat;
            out_reg.position_error <= err_reg;
            out_reg.no_signal      <= nosig_reg;
            out_reg.feature_mask   <= mask_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* hdl/lssf_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the line sensor steering and features unit, bound to the top.
// Depends on lssf_pkg.
module lssf_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input lssf_pkg::result_t out_data
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result word changed");

    // an accepted frame keeps the input side busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after a frame");

    a_nosig_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.no_signal |-> out_data.position_error == '0)
        else $error("no signal with nonzero position error");

    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.position_error >= -16'sd16384)
                   && (out_data.position_error <= 16'sd24576))
        else $error("position error out of range");

endmodule

bind line_sensor_steering_and_features_unit lssf_checker u_lssf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

/* bench/tb_line_sensor_steering_and_features_unit.sv */
`timescale 1ns / 1ps
// Self-checking bench for line_sensor_steering_and_features_unit: directed and random sensor
// frames, with the expected steering word predicted locally. Depends on lssf_pkg and the RTL.

// Tracks gains, thresholds and the last position error, and holds the words still owed.
class steer_checker;
    logic [lssf_pkg::GAIN_W-1:0]   prop_gain;
    logic [lssf_pkg::GAIN_W-1:0]   deriv_gain;
    logic [lssf_pkg::SAMPLE_W-1:0] line_thr;
    logic [lssf_pkg::SAMPLE_W-1:0] center_thr;
    int                            last_error;
    lssf_pkg::result_t             owed_words[$];
    int                            errors;
    int                            checked;
    int                            blind_frames;
    int                            clipped;

    function new();
        prop_gain    = lssf_pkg::PROP_GAIN_RST;
        deriv_gain   = lssf_pkg::DERIV_GAIN_RST;
        line_thr     = lssf_pkg::LINE_THR_RST;
        center_thr   = lssf_pkg::CENTER_THR_RST;
        last_error   = 0;
        errors       = 0;
        checked      = 0;
        blind_frames = 0;
        clipped      = 0;
    endfunction

    function void write_reg(logic [lssf_pkg::CFG_IDX_W-1:0] idx,
                            logic [lssf_pkg::CFG_W-1:0] data);
        case (idx)
            lssf_pkg::CFG_PROP_GAIN:  prop_gain  = data;
            lssf_pkg::CFG_DERIV_GAIN: deriv_gain = data;
            lssf_pkg::CFG_LINE_THR:   line_thr   = data[lssf_pkg::SAMPLE_W-1:0];
            lssf_pkg::CFG_CENTER_THR: center_thr = data[lssf_pkg::SAMPLE_W-1:0];
            default: ;
        endcase
    endfunction

    function lssf_pkg::result_t compute_steering(lssf_pkg::frame_t f);
        int                 fl, l, m, r, fr, ca, cb;
        int                 thr, cthr, pg, dg;
        int                 weighted, total, err, change;
        longint             acc, cmd;
        bit                 centers;
        lssf_pkg::result_t  res;
        fl   = f.sense_far_left;
        l    = f.sense_left;
        m    = f.sense_middle;
        r    = f.sense_right;
        fr   = f.sense_far_right;
        ca   = f.sense_center_a;
        cb   = f.sense_center_b;
        thr  = line_thr;
        cthr = center_thr;
        pg   = prop_gain;
        dg   = deriv_gain;

        weighted = 6 * fr + r - l - 4 * fl;
        total    = fl + l + m + r + fr;
        res.no_signal = (total == 0);
        // integer divide truncates toward zero, as the error needs
        err = (total == 0) ? 0 : (weighted * 4096) / total;
        change     = err - last_error;
        last_error = err;

        acc = longint'(err) * pg + longint'(change) * dg;
        cmd = acc >>> lssf_pkg::FRAC_W;
        if (cmd > lssf_pkg::CMD_MAX) cmd = lssf_pkg::CMD_MAX;
        else if (cmd < lssf_pkg::CMD_MIN) cmd = lssf_pkg::CMD_MIN;
        else clipped--;
        clipped++;

        centers = (ca >= thr) || (cb >= thr);
        res.feature_mask[0] = (fl >= thr) && (m >= thr) && (fr >= thr);
        res.feature_mask[1] = (ca >= cthr) || (cb >= cthr);
        res.feature_mask[2] = (m >= thr) && (ca >= thr) && (cb >= thr);
        res.feature_mask[3] = (fl >= thr) || (l >= thr) || (m >= thr) || (r >= thr)
                              || (fr >= thr);
        res.feature_mask[4] = centers && (m >= thr);
        res.feature_mask[5] = centers || (r >= thr);
        res.feature_mask[6] = centers || (fl >= thr);

        res.steer_command  = cmd[lssf_pkg::CMD_W-1:0];
        res.position_error = err[lssf_pkg::ERR_W-1:0];
        if (total == 0) blind_frames++;
        return res;
    endfunction

    function void note_frame(lssf_pkg::frame_t f);
        owed_words.push_back(compute_steering(f));
    endfunction

    task report(string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        errors++;
    endtask

    task check_result(lssf_pkg::result_t got);
        lssf_pkg::result_t want;
        if (owed_words.size() == 0)
        begin
            report($sformatf("unexpected result word %h", got));
        end
        else
        begin
            want = owed_words.pop_front();
            checked++;
            if (got.steer_command !== want.steer_command)
                report($sformatf("word %0d steer_command %0d, want %0d",
                                 checked, got.steer_command, want.steer_command));
            if (got.position_error !== want.position_error)
                report($sformatf("word %0d position_error %0d, want %0d",
                                 checked, got.position_error, want.position_error));
            if (got.no_signal !== want.no_signal)
                report($sformatf("word %0d no_signal %b, want %b",
                                 checked, got.no_signal, want.no_signal));
            if (got.feature_mask !== want.feature_mask)
                report($sformatf("word %0d feature_mask %b, want %b",
                                 checked, got.feature_mask, want.feature_mask));
        end
    endtask
endclass

module tb_line_sensor_steering_and_features_unit;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 7;
    localparam int PHASES         = 8;
    localparam int PHASE_FRAMES   = 191;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 40;
    localparam int PRESSURE_AT    = 500;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              in_valid  = 1'b0;
    logic                              in_stall;
    lssf_pkg::frame_t                  in_data   = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    lssf_pkg::result_t                 out_data;
    logic                              cfg_we    = 1'b0;
    logic [lssf_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [lssf_pkg::CFG_W-1:0]        cfg_data  = '0;

    steer_checker tracker;
    bit           calm_tail = 1'b0;
    int           settings_used = 0;
    int           words_taken = 0;
    int           hold_left = 0;
    int           burst_left = 0;
    bit           hold_done = 1'b0;
    int           stuck_cycles = 0;

    line_sensor_steering_and_features_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // Result side: check each accepted word, then pick next cycle's stall.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            tracker.check_result(out_data);
            words_taken++;
        end
        if (hold_left > 0)
            hold_left--;
        else if (words_taken == PRESSURE_AT && !hold_done)
        begin
            // long hold-off so the unit backs up and stalls its input
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        else if (burst_left > 0)
            burst_left--;
        else if (!calm_tail && $urandom_range(0, 5) == 0)
            burst_left = $urandom_range(1, 9);
        out_stall <= (hold_left > 0) || (burst_left > 0);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_line_sensor_steering_and_features_unit failed");
            $finish;
        end
    end

    function automatic lssf_pkg::frame_t make_frame(int fl, int l, int m, int r, int fr,
                                                     int ca, int cb);
        lssf_pkg::frame_t f;
        f.sense_far_left  = lssf_pkg::SAMPLE_W'(fl);
        f.sense_left      = lssf_pkg::SAMPLE_W'(l);
        f.sense_middle    = lssf_pkg::SAMPLE_W'(m);
        f.sense_right     = lssf_pkg::SAMPLE_W'(r);
        f.sense_far_right = lssf_pkg::SAMPLE_W'(fr);
        f.sense_center_a  = lssf_pkg::SAMPLE_W'(ca);
        f.sense_center_b  = lssf_pkg::SAMPLE_W'(cb);
        return f;
    endfunction

    // Mostly full range, with a bias toward the rails and the given threshold.
    function automatic logic [lssf_pkg::SAMPLE_W-1:0] pick_sample(
            logic [lssf_pkg::SAMPLE_W-1:0] near);
        int v;
        case ($urandom_range(0, 7))
            0:       v = 0;
            1:       v = 4095;
            2, 3:    v = int'(near) + int'($urandom_range(0, 4)) - 2;
            default: v = $urandom_range(0, 4095);
        endcase
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v[lssf_pkg::SAMPLE_W-1:0];
    endfunction

    function automatic lssf_pkg::frame_t random_frame();
        lssf_pkg::frame_t f;
        int               pick;
        f.sense_far_left  = pick_sample(tracker.line_thr);
        f.sense_left      = pick_sample(tracker.line_thr);
        f.sense_middle    = pick_sample(tracker.line_thr);
        f.sense_right     = pick_sample(tracker.line_thr);
        f.sense_far_right = pick_sample(tracker.line_thr);
        f.sense_center_a  = pick_sample($urandom_range(0, 1) ? tracker.center_thr
                                                             : tracker.line_thr);
        f.sense_center_b  = pick_sample($urandom_range(0, 1) ? tracker.center_thr
                                                             : tracker.line_thr);
        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            // dark front row: no signal
            f.sense_far_left  = '0;
            f.sense_left      = '0;
            f.sense_middle    = '0;
            f.sense_right     = '0;
            f.sense_far_right = '0;
        end
        else if (pick == 1)
        begin
            // one lit front sensor drives the error to a weight
            f.sense_far_left  = $urandom_range(0, 1) ? f.sense_far_left : '0;
            f.sense_left      = '0;
            f.sense_middle    = '0;
            f.sense_right     = '0;
            f.sense_far_right = f.sense_far_left == 0 ? f.sense_far_right : '0;
        end
        else if (pick == 2)
        begin
            // tiny sums make the quotient truncation visible
            f.sense_far_left  = lssf_pkg::SAMPLE_W'($urandom_range(0, 3));
            f.sense_left      = lssf_pkg::SAMPLE_W'($urandom_range(0, 3));
            f.sense_middle    = lssf_pkg::SAMPLE_W'($urandom_range(0, 3));
            f.sense_right     = lssf_pkg::SAMPLE_W'($urandom_range(0, 3));
            f.sense_far_right = lssf_pkg::SAMPLE_W'($urandom_range(0, 3));
        end
        return f;
    endfunction

    task send_frame(input lssf_pkg::frame_t f);
        in_data  <= f;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        tracker.note_frame(f);
        if (!calm_tail && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task wait_idle();
        in_valid <= 1'b0;
        while (tracker.owed_words.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task apply_settings(input logic [15:0] pg, input logic [15:0] dg,
                        input logic [11:0] lthr, input logic [11:0] cthr);
        logic [lssf_pkg::CFG_IDX_W-1:0] idx [4];
        logic [lssf_pkg::CFG_W-1:0]     val [4];
        idx = '{lssf_pkg::CFG_PROP_GAIN, lssf_pkg::CFG_DERIV_GAIN,
                lssf_pkg::CFG_LINE_THR, lssf_pkg::CFG_CENTER_THR};
        // junk in the unused upper threshold bits must be dropped
        val = '{pg, dg, {4'($urandom), lthr}, {4'($urandom), cthr}};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            tracker.write_reg(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        lssf_pkg::frame_t at_reset [$];
        lssf_pkg::frame_t at_limits [$];
        int               thr;
        int               cthr;
        tracker = new();
        thr  = lssf_pkg::LINE_THR_RST;
        cthr = lssf_pkg::CENTER_THR_RST;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset gains and thresholds
        at_reset.push_back(make_frame(0, 0, 0, 0, 0, 0, 0));
        at_reset.push_back(make_frame(4095, 4095, 4095, 4095, 4095, 4095, 4095));
        at_reset.push_back(make_frame(4095, 0, 0, 0, 0, 0, 0));
        at_reset.push_back(make_frame(0, 0, 0, 0, 4095, 0, 0));
        at_reset.push_back(make_frame(0, 0, 0, 0, 1, 0, 0));
        at_reset.push_back(make_frame(0, 1, 0, 0, 0, 0, 0));
        at_reset.push_back(make_frame(0, 0, 4095, 0, 0, 0, 0));
        at_reset.push_back(make_frame(0, 0, 0, 1, 0, 0, 0));
        at_reset.push_back(make_frame(1, 0, 0, 0, 1, 0, 0));
        at_reset.push_back(make_frame(thr, thr, thr, thr, thr, cthr, cthr));
        at_reset.push_back(make_frame(thr - 1, thr - 1, thr - 1, thr - 1, thr - 1,
                                      cthr - 1, cthr - 1));
        at_reset.push_back(make_frame(0, 0, 0, 0, 0, cthr, 0));
        at_reset.push_back(make_frame(0, 0, thr, 0, 0, thr, thr - 1));
        at_reset.push_back(make_frame(thr, 0, 0, 0, 0, 0, 0));
        at_reset.push_back(make_frame(0, 0, 0, thr, 0, 0, 0));
        at_reset.push_back(make_frame(1, 0, 0, 2, 0, 0, 0));
        foreach (at_reset[i]) send_frame(at_reset[i]);
        wait_idle();

        // full gains, zero thresholds: saturation both ways, derivative swings
        apply_settings(16'hFFFF, 16'hFFFF, 12'd0, 12'd0);
        at_limits.push_back(make_frame(0, 0, 0, 0, 4095, 0, 0));
        at_limits.push_back(make_frame(4095, 0, 0, 0, 0, 0, 0));
        at_limits.push_back(make_frame(0, 0, 0, 0, 0, 0, 0));
        at_limits.push_back(make_frame(1, 0, 0, 0, 0, 0, 0));
        at_limits.push_back(make_frame(1, 0, 0, 2, 0, 0, 0));
        at_limits.push_back(make_frame(0, 0, 2, 1, 0, 4095, 4095));
        foreach (at_limits[i]) send_frame(at_limits[i]);
        wait_idle();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: apply_settings(16'd0, 16'd0, 12'd4095, 12'd4095);
                1: apply_settings(lssf_pkg::PROP_GAIN_RST, lssf_pkg::DERIV_GAIN_RST,
                                  lssf_pkg::LINE_THR_RST, lssf_pkg::CENTER_THR_RST);
                2: apply_settings(16'd0, 16'hFFFF, 12'd1, 12'd2048);
                PHASES - 1:
                   apply_settings(16'hFFFF, 16'($urandom_range(0, 8192)),
                                  12'($urandom), 12'($urandom));
                default:
                   apply_settings(16'($urandom), 16'($urandom), 12'($urandom),
                                  12'($urandom));
            endcase
            // no idling on either side in the final stretch
            if (phase == PHASES - 1) calm_tail = 1'b1;
            for (int n = 0; n < PHASE_FRAMES; n++) send_frame(random_frame());
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Ran %0d frames through %0d gain/threshold settings after reset defaults;",
                 tracker.checked, settings_used);
        $display("%0d frames had a dark front row and %0d commands hit the clip limits.",
                 tracker.blind_frames, tracker.clipped);
        if (tracker.errors == 0)
            $display("tb_line_sensor_steering_and_features_unit passed");
        else
            $display("tb_line_sensor_steering_and_features_unit failed");
        $finish;
    end

endmodule
